/* sv/pinhole_project_with_lens_distortion_core_defines.svh */
// Assertion macros shared by the pinhole projection RTL.
`ifndef PINHOLE_PROJECT_WITH_LENS_DISTORTION_CORE_DEFINES_SVH
`define PINHOLE_PROJECT_WITH_LENS_DISTORTION_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PLDC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define PLDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

/* sv/pldc_pkg.sv */
// Types, constants and arithmetic helpers for the pinhole projection core.
`timescale 1ns / 1ps
`default_nettype none
package pldc_pkg;

  localparam int DIV_LAT = 18;
  localparam int NFRAC = 24;
  localparam int CFRAC = 28;

  localparam logic [2:0] REG_FOCAL_X = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_RADIAL_K1 = 3'd4;
  localparam logic [2:0] REG_RADIAL_K2 = 3'd5;
  localparam logic [2:0] REG_TANG_P1 = 3'd6;
  localparam logic [2:0] REG_TANG_P2 = 3'd7;

  localparam logic [31:0] FOCAL_RESET = 32'd4096000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [63:0] Q_ONE = 64'sd16777216;

  // Side information that travels with every pipeline slot.
  typedef struct packed {
    logic vld;
    logic pos;
    logic sat;
  } side_t;

  // Round to nearest with ties upward, then arithmetic shift right.
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input int unsigned s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return !((&v[63:31]) || !(|v[63:31]));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (ovf32(v)) begin
      return v[63] ? Q_MIN : Q_MAX;
    end
    return v[31:0];
  endfunction

  // One restoring division step: {quotient bit, new remainder}.
  function automatic logic [31:0] div_step(input logic [30:0] r, input logic b,
                                           input logic [30:0] d);
    logic [31:0] t;
    logic ge;
    t = {r, b};
    ge = (t >= {1'b0, d});
    if (ge) begin
      t = t - {1'b0, d};
    end
    return {ge, t[30:0]};
  endfunction

endpackage
`default_nettype wire

/* sv/pldc_divider.sv */
// Pipelined restoring divider giving a signed Q7.24 ratio, two bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module pldc_divider (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic signed [31:0]      quot,
  output logic                    ovf
);
  import pldc_pkg::*;

  logic [30:0] rem [0:16];
  logic [31:0] nb  [0:16];
  logic [31:0] quo [0:16];
  logic [30:0] dv  [0:16];
  logic        ng  [0:16];
  logic        bg  [0:16];

  logic [31:0] mag;
  logic [30:0] d_in;
  logic [32:0] qsum;
  logic [31:0] qr;

  assign mag = num[31] ? (~num + 32'd1) : num;
  assign d_in = den[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ng[0] <= num[31];
      dv[0] <= d_in;
      bg[0] <= ({6'b0, mag} >= {d_in, 7'b0});
      rem[0] <= {6'b0, mag[31:7]};
      nb[0] <= {mag[6:0], 25'b0};
      quo[0] <= '0;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_iter
    logic [31:0] s1;
    logic [31:0] s2;
    assign s1 = div_step(rem[k], nb[k][31], dv[k]);
    assign s2 = div_step(s1[30:0], nb[k][30], dv[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= s2[30:0];
        nb[k+1] <= {nb[k][29:0], 2'b0};
        quo[k+1] <= {quo[k][29:0], s1[31], s2[31]};
        dv[k+1] <= dv[k];
        ng[k+1] <= ng[k];
        bg[k+1] <= bg[k];
      end
    end
  end

  assign qsum = {1'b0, quo[16]} + 33'd1;
  assign qr = qsum[32:1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (bg[16]) begin
        quot <= ng[16] ? Q_MIN : Q_MAX;
        ovf <= 1'b1;
      end else if (!ng[16]) begin
        quot <= qr[31] ? Q_MAX : qr;
        ovf <= qr[31];
      end else begin
        quot <= ~qr + 32'd1;
        ovf <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/pldc_distort.sv */
// Brown-Conrady radial and tangential distortion pipeline in Q7.24.
`timescale 1ns / 1ps
`default_nettype none
module pldc_distort (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire pldc_pkg::side_t    side_in,
  input  wire logic signed [31:0] nx,
  input  wire logic signed [31:0] ny,
  input  wire logic signed [31:0] k1,
  input  wire logic signed [31:0] k2,
  input  wire logic signed [31:0] p1,
  input  wire logic signed [31:0] p2,
  output pldc_pkg::side_t         side_out,
  output logic signed [31:0]      dx,
  output logic signed [31:0]      dy
);
  import pldc_pkg::*;

  side_t side1, side2, side3, side4, side5, side6, side7, side8;
  logic signed [31:0] nx1, ny1, nx2, ny2, nx3, ny3, nx4, ny4;
  logic signed [31:0] nx5, ny5, nx6, ny6, nx7, ny7;
  logic signed [63:0] pxx, pyy, pxy;
  logic signed [31:0] xx2, yy2, xy2;
  logic signed [31:0] xx3, yy3, r23, txy3;
  logic signed [31:0] sx4, sy4, txy4;
  logic signed [63:0] r4p, k1p;
  logic signed [31:0] r45, k1t5;
  logic signed [63:0] tax5, tbx5, tay5, tby5;
  logic signed [63:0] k2p;
  logic signed [31:0] k1t6, tax6, tbx6, tay6, tby6;
  logic signed [31:0] rad7, tax7, tbx7, tay7, tby7;
  logic signed [63:0] mx8, my8;
  logic signed [31:0] tax8, tbx8, tay8, tby8;

  logic signed [63:0] rxx, ryy, rxy;
  logic signed [63:0] s_r2, s_txy, s_sx, s_sy;
  logic signed [63:0] rr4, rk1, rta, rtb, rtc, rtd, rk2, s_rad;
  logic signed [63:0] rmx, rmy, s_dx, s_dy;

  assign rxx = rshr(pxx, NFRAC);
  assign ryy = rshr(pyy, NFRAC);
  assign rxy = rshr(pxy, NFRAC);
  assign s_r2 = 64'(xx2) + 64'(yy2);
  assign s_txy = 64'(xy2) * 64'sd2;
  assign s_sx = 64'(r23) + 64'(xx3) * 64'sd2;
  assign s_sy = 64'(r23) + 64'(yy3) * 64'sd2;
  assign rr4 = rshr(r4p, NFRAC);
  assign rk1 = rshr(k1p, CFRAC);
  assign rta = rshr(tax5, CFRAC);
  assign rtb = rshr(tbx5, CFRAC);
  assign rtc = rshr(tay5, CFRAC);
  assign rtd = rshr(tby5, CFRAC);
  assign rk2 = rshr(k2p, CFRAC);
  assign s_rad = Q_ONE + 64'(k1t6) + 64'(sat32(rk2));
  assign rmx = rshr(mx8, NFRAC);
  assign rmy = rshr(my8, NFRAC);
  assign s_dx = 64'(sat32(rmx)) + 64'(tax8) + 64'(tbx8);
  assign s_dy = 64'(sat32(rmy)) + 64'(tay8) + 64'(tby8);

  always_ff @(posedge clk) begin
    if (rst) begin
      side1 <= '0;
      side2 <= '0;
      side3 <= '0;
      side4 <= '0;
      side5 <= '0;
      side6 <= '0;
      side7 <= '0;
      side8 <= '0;
      side_out <= '0;
    end else if (en) begin
      // Squares and cross product.
      side1 <= side_in;
      nx1 <= nx;
      ny1 <= ny;
      pxx <= 64'(nx) * 64'(nx);
      pyy <= 64'(ny) * 64'(ny);
      pxy <= 64'(nx) * 64'(ny);

      side2 <= '{vld: side1.vld, pos: side1.pos,
                 sat: side1.sat | ovf32(rxx) | ovf32(ryy) | ovf32(rxy)};
      nx2 <= nx1;
      ny2 <= ny1;
      xx2 <= sat32(rxx);
      yy2 <= sat32(ryy);
      xy2 <= sat32(rxy);

      side3 <= '{vld: side2.vld, pos: side2.pos,
                 sat: side2.sat | ovf32(s_r2) | ovf32(s_txy)};
      nx3 <= nx2;
      ny3 <= ny2;
      xx3 <= xx2;
      yy3 <= yy2;
      r23 <= sat32(s_r2);
      txy3 <= sat32(s_txy);

      // Radial powers and tangential terms.
      side4 <= '{vld: side3.vld, pos: side3.pos,
                 sat: side3.sat | ovf32(s_sx) | ovf32(s_sy)};
      nx4 <= nx3;
      ny4 <= ny3;
      sx4 <= sat32(s_sx);
      sy4 <= sat32(s_sy);
      txy4 <= txy3;
      r4p <= 64'(r23) * 64'(r23);
      k1p <= 64'(k1) * 64'(r23);

      side5 <= '{vld: side4.vld, pos: side4.pos,
                 sat: side4.sat | ovf32(rr4) | ovf32(rk1)};
      nx5 <= nx4;
      ny5 <= ny4;
      r45 <= sat32(rr4);
      k1t5 <= sat32(rk1);
      tax5 <= 64'(p1) * 64'(txy4);
      tbx5 <= 64'(p2) * 64'(sx4);
      tay5 <= 64'(p1) * 64'(sy4);
      tby5 <= 64'(p2) * 64'(txy4);

      side6 <= '{vld: side5.vld, pos: side5.pos,
                 sat: side5.sat | ovf32(rta) | ovf32(rtb) | ovf32(rtc) | ovf32(rtd)};
      nx6 <= nx5;
      ny6 <= ny5;
      k2p <= 64'(k2) * 64'(r45);
      k1t6 <= k1t5;
      tax6 <= sat32(rta);
      tbx6 <= sat32(rtb);
      tay6 <= sat32(rtc);
      tby6 <= sat32(rtd);

      side7 <= '{vld: side6.vld, pos: side6.pos,
                 sat: side6.sat | ovf32(rk2) | ovf32(s_rad)};
      nx7 <= nx6;
      ny7 <= ny6;
      rad7 <= sat32(s_rad);
      tax7 <= tax6;
      tbx7 <= tbx6;
      tay7 <= tay6;
      tby7 <= tby6;

      // Scale by the radial factor and add the tangential terms.
      side8 <= side7;
      mx8 <= 64'(nx7) * 64'(rad7);
      my8 <= 64'(ny7) * 64'(rad7);
      tax8 <= tax7;
      tbx8 <= tbx7;
      tay8 <= tay7;
      tby8 <= tby7;

      side_out <= '{vld: side8.vld, pos: side8.pos,
                    sat: side8.sat | ovf32(rmx) | ovf32(rmy) | ovf32(s_dx) | ovf32(s_dy)};
      dx <= sat32(s_dx);
      dy <= sat32(s_dy);
    end
  end

endmodule
`default_nettype wire

/* sv/pldc_pixel.sv */
// Focal scaling and principal point offset into Q19.12 pixel coordinates.
`timescale 1ns / 1ps
`default_nettype none
module pldc_pixel (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire pldc_pkg::side_t    side_in,
  input  wire logic signed [31:0] dx,
  input  wire logic signed [31:0] dy,
  input  wire logic [31:0]        focal_x,
  input  wire logic [31:0]        focal_y,
  input  wire logic [31:0]        center_x,
  input  wire logic [31:0]        center_y,
  output pldc_pkg::side_t         side_out,
  output logic signed [31:0]      u,
  output logic signed [31:0]      v
);
  import pldc_pkg::*;

  side_t side1;
  logic signed [63:0] pu, pv;
  logic signed [63:0] su, sv;

  assign su = rshr(pu, NFRAC) + $signed({32'd0, center_x});
  assign sv = rshr(pv, NFRAC) + $signed({32'd0, center_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      side1 <= '0;
      side_out <= '0;
    end else if (en) begin
      side1 <= side_in;
      pu <= $signed({32'd0, focal_x}) * 64'(dx);
      pv <= $signed({32'd0, focal_y}) * 64'(dy);
      side_out <= '{vld: side1.vld, pos: side1.pos,
                    sat: side1.sat | ovf32(su) | ovf32(sv)};
      u <= sat32(su);
      v <= sat32(sv);
    end
  end

endmodule
`default_nettype wire

/* sv/pinhole_project_with_lens_distortion_core.sv */
// Pinhole projection with Brown-Conrady distortion, fully pipelined top level.
// A point passes the divider, distortion and pixel stages and then the output register.
// Throughput: one point per cycle; the two 18-stage dividers, nine distortion stages
// and two pixel stages all advance together whenever the output register is free.
// Reset (rst, synchronous, active high) clears the valid bits and restores the
// configuration registers; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "pinhole_project_with_lens_distortion_core_defines.svh"
module pinhole_project_with_lens_distortion_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      pixel_u,
  output logic signed [31:0]      pixel_v,
  output logic                    valid_res,
  output logic                    saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import pldc_pkg::*;

  // Configuration registers.
  logic [31:0] focal_x, focal_y, center_x, center_y;
  logic signed [31:0] radial_k1, radial_k2, tangential_p1, tangential_p2;

  // The whole pipeline moves as one whenever the output register can take a
  // new slot, so a stall holds every stage in place and nothing is lost.
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= FOCAL_RESET;
      focal_y <= FOCAL_RESET;
      center_x <= '0;
      center_y <= '0;
      radial_k1 <= '0;
      radial_k2 <= '0;
      tangential_p1 <= '0;
      tangential_p2 <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL_X: focal_x <= cfg_data;
        REG_FOCAL_Y: focal_y <= cfg_data;
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_RADIAL_K1: radial_k1 <= cfg_data;
        REG_RADIAL_K2: radial_k2 <= cfg_data;
        REG_TANG_P1: tangential_p1 <= cfg_data;
        REG_TANG_P2: tangential_p2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Side information runs alongside the divider; a point with non-positive
  // depth still flows through so that ordering is kept, and is zeroed at the end.
  side_t div_side [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        div_side[i] <= '0;
      end
    end else if (en) begin
      div_side[0] <= '{vld: in_valid, pos: !point_z[31] && (point_z != 32'sd0), sat: 1'b0};
      for (int i = 1; i < DIV_LAT; i++) begin
        div_side[i] <= div_side[i-1];
      end
    end
  end

  logic signed [31:0] nx, ny;
  logic ovf_x, ovf_y;

  pldc_divider u_div_x (
    .clk  (clk),
    .en   (en),
    .num  (point_x),
    .den  (point_z),
    .quot (nx),
    .ovf  (ovf_x)
  );

  pldc_divider u_div_y (
    .clk  (clk),
    .en   (en),
    .num  (point_y),
    .den  (point_z),
    .quot (ny),
    .ovf  (ovf_y)
  );

  side_t dist_side_in, dist_side_out, pix_side_out;
  logic signed [31:0] dx, dy, u, v;

  assign dist_side_in = '{vld: div_side[DIV_LAT-1].vld, pos: div_side[DIV_LAT-1].pos,
                          sat: ovf_x | ovf_y};

  pldc_distort u_distort (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (dist_side_in),
    .nx       (nx),
    .ny       (ny),
    .k1       (radial_k1),
    .k2       (radial_k2),
    .p1       (tangential_p1),
    .p2       (tangential_p2),
    .side_out (dist_side_out),
    .dx       (dx),
    .dy       (dy)
  );

  pldc_pixel u_pixel (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (dist_side_out),
    .dx       (dx),
    .dy       (dy),
    .focal_x  (focal_x),
    .focal_y  (focal_y),
    .center_x (center_x),
    .center_y (center_y),
    .side_out (pix_side_out),
    .u        (u),
    .v        (v)
  );

  // Output register: a point with non-positive depth yields an all-zero result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pix_side_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_u <= pix_side_out.pos ? u : '0;
      pixel_v <= pix_side_out.pos ? v : '0;
      valid_res <= pix_side_out.pos;
      saturated <= pix_side_out.pos & pix_side_out.sat;
    end
  end

  `PLDC_ASSERT_IMP(a_invalid_zero, out_valid && !valid_res,
                   !saturated && pixel_u == 32'sd0 && pixel_v == 32'sd0)
  `PLDC_ASSERT_IMP(a_stall_only_when_full, !in_ready, out_valid && !out_ready)
  `PLDC_ASSERT_NEXT(a_pipe_holds, !en && pix_side_out.vld, pix_side_out.vld)

endmodule
`default_nettype wire
